>>> rtl/tbgsa_pkg.sv
// Shared types and constants for the two-bank grid slot allocator.
`default_nettype none

package tbgsa_pkg;

  localparam int unsigned MAX_COLUMNS = 8;
  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned NUM_BANKS   = 2;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BANK_W  = 1;
  localparam int unsigned COL_W   = 3;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIND   = 2'd0,
    KIND_OCCUPY = 2'd1,
    KIND_FREE   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1
  } cfg_reg_e;

  localparam logic [SIZE_W-1:0] COLUMNS_RESET = 4'd7;
  localparam logic [SIZE_W-1:0] ROWS_RESET    = 4'd8;

  // Result of one item as it moves towards the output register.
  typedef struct packed {
    logic             hit;
    logic [COL_W-1:0] found_column;
    logic [ROW_W-1:0] found_row;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/two_bank_grid_slot_allocator.sv
// Two-bank occupancy bitmap with occupy, free, query and find-first-free.
//
// Input channel (in_valid_i/in_ready_o) takes one item: kind, bank, column, row.
// Output channel (out_valid_o/out_ready_i) returns one result per item: hit and,
// for a successful find, the column and row of the first free cell.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes columns_in_use
// (index 0) and rows_in_use (index 1); other indexes are dropped.
// The block works on one item at a time. Occupy, free and query read the row
// word in the EXEC state, where occupy and free also write the cell back; the
// result is registered and then moved to the output register. Find runs the
// shared row unit (mask and priority encoder) once per row, row 0 first, and
// stops at the first free cell or after the last row in use. A new item is
// taken only after the last result has moved to the output register:
// in_ready_o is high only while the sequencer idles.
// A finished result waits in a holding register while the output register is
// still occupied by an untaken result; the sequencer then holds.
// Reset clears both bitmaps to all free, loads columns_in_use 7, rows_in_use 8,
// and leaves the output channel empty.
`default_nettype none

module two_bank_grid_slot_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [tbgsa_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [tbgsa_pkg::BANK_W-1:0]    bank_i,
  input  wire logic [tbgsa_pkg::COL_W-1:0]     column_i,
  input  wire logic [tbgsa_pkg::ROW_W-1:0]     row_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 hit_o,
  output logic [tbgsa_pkg::COL_W-1:0]          found_column_o,
  output logic [tbgsa_pkg::ROW_W-1:0]          found_row_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tbgsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [tbgsa_pkg::SIZE_W-1:0]    cfg_data_i
);
  import tbgsa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SIZE_W-1:0] columns_q, rows_q;

  logic [MAX_COLUMNS-1:0] map_q [NUM_BANKS][MAX_ROWS];

  // Accepted item
  kind_e             kind_q;
  logic [BANK_W-1:0] bank_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;

  logic [ROW_W-1:0]  row_cnt_q, row_cnt_d;

  result_t res_q, res_d;
  result_t out_q;
  logic    out_valid_q;

  logic [SIZE_W-1:0]      cols_used, rows_used;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [ROW_W-1:0]       rd_row;
  logic [MAX_COLUMNS-1:0] rd_word;
  logic [MAX_COLUMNS-1:0] free_bits;
  logic                   any_free;
  logic [COL_W-1:0]       first_free;
  logic                   cell_in_use;
  logic                   cell_bit;
  logic                   last_row;
  logic                   map_we;
  logic                   map_set;
  logic                   in_xfer, out_load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_q.hit;
  assign found_column_o = out_q.found_column;
  assign found_row_o    = out_q.found_row;

  // Saturate size registers at the grid size
  assign cols_used = (columns_q > SIZE_W'(MAX_COLUMNS)) ? SIZE_W'(MAX_COLUMNS) : columns_q;
  assign rows_used = (rows_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : rows_q;

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = (SIZE_W'(c) < cols_used);
    end
  end

  // Shared row unit: one row word, masked, priority encoded
  assign rd_row    = (state_q == ST_SCAN) ? row_cnt_q : row_q;
  assign rd_word   = map_q[bank_q][rd_row];
  assign free_bits = (SIZE_W'(rd_row) < rows_used) ? (~rd_word & col_mask) : '0;
  assign any_free  = |free_bits;

  always_comb begin
    first_free = '0;
    for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
      if (free_bits[c]) begin
        first_free = COL_W'(c);
      end
    end
  end

  assign cell_in_use = (SIZE_W'(col_q) < cols_used) && (SIZE_W'(row_q) < rows_used);
  assign cell_bit    = rd_word[col_q];
  assign last_row    = (SIZE_W'(row_cnt_q) + SIZE_W'(1)) >= rows_used;
  assign map_we      = (state_q == ST_EXEC) && cell_in_use &&
                       (kind_q inside {KIND_OCCUPY, KIND_FREE});
  assign map_set     = (kind_q == KIND_OCCUPY);

  always_comb begin
    state_d   = state_q;
    row_cnt_d = row_cnt_q;
    res_d     = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          row_cnt_d = '0;
          state_d   = (kind_e'(kind_i) == KIND_FIND) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d.found_column = '0;
        res_d.found_row    = '0;
        case (kind_q)
          KIND_QUERY: res_d.hit = cell_in_use && !cell_bit;
          default:    res_d.hit = cell_in_use;
        endcase
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (any_free) begin
          res_d.hit          = 1'b1;
          res_d.found_column = first_free;
          res_d.found_row    = row_cnt_q;
          state_d            = ST_DONE;
        end else if (last_row) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          row_cnt_d = row_cnt_q + ROW_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      columns_q   <= COLUMNS_RESET;
      rows_q      <= ROWS_RESET;
    end else begin
      state_q   <= state_d;
      row_cnt_q <= row_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_COLUMNS: columns_q <= cfg_data_i;
          CFG_ROWS:    rows_q    <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  // Occupancy bitmaps, all free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        for (int r = 0; r < MAX_ROWS; r++) begin
          map_q[b][r] <= '0;
        end
      end
    end else if (map_we) begin
      map_q[bank_q][row_q][col_q] <= map_set;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q <= kind_e'(kind_i);
      bank_q <= bank_i;
      col_q  <= column_i;
      row_q  <= row_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_EXEC) || (state_q == ST_SCAN))
    else $error("accepted item did not start the sequencer");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished result not moved to the output register");

  a_miss_has_no_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (found_column_o == '0) && (found_row_o == '0))
    else $error("result without hit carries a cell position");
`endif

endmodule

`default_nettype wire
